/* design/bba_pkg.sv */
package bba_pkg;

  // Sizing of the usage map
  localparam int NUM_BLOCKS  = 4096;
  localparam int BLOCK_BYTES = 4096;
  localparam int WORD_BITS   = 64;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int MAP_WORDS   = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIDX_W      = WADDR_W + BIT_W;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int IDX_W    = 12;
  localparam int STATUS_W = 2;
  localparam int OFS_W    = 24;
  localparam int FIRST_W  = 12;
  localparam int TOTAL_W  = 13;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TOTAL_W;

  // Internal block count width: holds NUM_BLOCKS and any total_blocks value
  localparam int LIM_W = $clog2(NUM_BLOCKS + 1);
  localparam int CNT_W = (LIM_W > TOTAL_W) ? LIM_W : TOTAL_W;

  localparam int BB_W  = $clog2(BLOCK_BYTES + 1);
  localparam int MUL_W = (CNT_W + BB_W > OFS_W) ? CNT_W + BB_W : OFS_W;

  typedef logic [MODE_W-1:0]     mode_t;
  typedef logic [STATUS_W-1:0]   status_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [WADDR_W-1:0]    waddr_t;
  typedef logic [BIT_W-1:0]      bitpos_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [MUL_W-1:0]      mul_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  localparam mode_t MODE_ALLOC   = 2'd0;
  localparam mode_t MODE_RESERVE = 2'd1;
  localparam mode_t MODE_FREE    = 2'd2;
  localparam mode_t MODE_TEST    = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  localparam cfg_idx_t CFG_FIRST_DATA = 1'b0;
  localparam cfg_idx_t CFG_TOTAL      = 1'b1;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

endpackage

/* design/bba_if.sv */
interface bba_req_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::MODE_W-1:0]  mode;
  logic [bba_pkg::IDX_W-1:0]   block_index;

  modport source (output valid, output mode, output block_index, input ready);
  modport sink   (input valid, input mode, input block_index, output ready);
endinterface

interface bba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::STATUS_W-1:0]  status;
  logic [bba_pkg::IDX_W-1:0]     found_index;
  logic [bba_pkg::OFS_W-1:0]     byte_offset;
  logic                          bit_value;

  modport source (output valid, output status, output found_index, output byte_offset,
                  output bit_value, input ready);
  modport sink   (input valid, input status, input found_index, input byte_offset,
                  input bit_value, output ready);
endinterface

/* design/block_bitmap_allocator_unit.sv */
// Channel   Dir  Handshake     Payload
// in_if     in   valid/ready   mode, block_index
// out_if    out  valid/ready   status, found_index, byte_offset, bit_value
// cfg_*     in   cfg_we        cfg_index, cfg_wdata (first_data_block, total_blocks)
//
// Reserve, free and test pass through S_EVAL and S_RESP before the result register loads
// and another request is taken; an out of range index or an empty search skips S_EVAL.
// Allocate stays in S_EVAL over the 64-bit map words scanned (at most 64) until a hit or the
// last word, one word read per cycle from the map memory and run through a 64-bit priority encoder.
// Reset is synchronous; a valid bit per map word makes the whole map read as free at once.
// A request is taken while a result waits in the output register; a stall holds the next.
module block_bitmap_allocator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  bba_req_if.sink                             in_if,
  bba_rsp_if.source                           out_if,
  input  logic                                cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [bba_pkg::FIRST_W-1:0] first_r;
  logic [bba_pkg::TOTAL_W-1:0] total_r;

  // Map storage
  bba_pkg::word_t                  map_mem [bba_pkg::MAP_WORDS];
  logic [bba_pkg::MAP_WORDS-1:0]   vld_r;
  bba_pkg::word_t                  rd_word_r;
  logic                            rd_vld_r;
  bba_pkg::waddr_t                 rd_addr;
  logic                            wr_en;
  bba_pkg::word_t                  wr_word;

  // Request context
  bba_pkg::mode_t                  mode_r;
  logic [bba_pkg::IDX_W-1:0]       idx_r;
  bba_pkg::waddr_t                 scan_w_r;

  // Pending result
  bba_pkg::status_t                res_status_r;
  bba_pkg::cnt_t                   res_blk_r;
  logic                            res_ofs_en_r;
  logic                            res_bit_r;

  // Output register
  logic                            out_valid_r;
  bba_pkg::status_t                out_status_r;
  logic [bba_pkg::IDX_W-1:0]       out_found_r;
  logic [bba_pkg::OFS_W-1:0]       out_ofs_r;
  logic                            out_bit_r;

  bba_pkg::cnt_t                   limit;
  bba_pkg::cnt_t                   search_end;
  bba_pkg::cnt_t                   first_ext;
  bba_pkg::cnt_t                   in_idx_ext;
  logic                            in_xfer;
  logic                            out_free;

  bba_pkg::word_t                  cur_word;
  bba_pkg::word_t                  elig;
  bba_pkg::word_t                  cand;
  logic                            hit;
  bba_pkg::bitpos_t                hit_pos;
  bba_pkg::cnt_t                   base;
  logic                            last_word;
  bba_pkg::bitpos_t                op_pos;
  bba_pkg::word_t                  op_mask;
  bba_pkg::mul_t                   prod;

  assign in_xfer  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE);

  assign first_ext  = bba_pkg::cnt_t'(first_r);
  assign in_idx_ext = bba_pkg::cnt_t'(in_if.block_index);

  // Usable limit and allocate search bound
  always_comb begin
    bba_pkg::cnt_t tot;
    bba_pkg::cnt_t e;
    tot = bba_pkg::cnt_t'(total_r);
    limit = (tot < bba_pkg::cnt_t'(bba_pkg::NUM_BLOCKS)) ? tot
                                                         : bba_pkg::cnt_t'(bba_pkg::NUM_BLOCKS);
    e = (tot != '0) ? tot - bba_pkg::cnt_t'(1) : '0;
    search_end = (e > limit) ? limit : e;
  end

  // Word evaluation: eligibility mask and lowest free bit
  assign cur_word = rd_vld_r ? rd_word_r : '0;
  assign base = bba_pkg::cnt_t'(scan_w_r) << bba_pkg::BIT_W;

  always_comb begin
    bba_pkg::cnt_t blk;
    for (int j = 0; j < bba_pkg::WORD_BITS; j++) begin
      blk = base + bba_pkg::cnt_t'(j);
      elig[j] = (blk >= first_ext) && (blk < search_end);
    end
  end

  assign cand = ~cur_word & elig;
  assign hit  = |cand;
  assign last_word = (base + bba_pkg::cnt_t'(bba_pkg::WORD_BITS)) >= search_end;

  always_comb begin
    hit_pos = '0;
    for (int j = bba_pkg::WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit_pos = bba_pkg::bitpos_t'(j);
      end
    end
  end

  assign op_pos  = idx_r[bba_pkg::BIT_W-1:0];
  assign op_mask = bba_pkg::word_t'(1) << op_pos;

  // Read address: start word on transfer, next word while scanning
  always_comb begin
    if (state_r == S_IDLE) begin
      if (in_if.mode == bba_pkg::MODE_ALLOC) begin
        rd_addr = bba_pkg::waddr_t'(first_ext >> bba_pkg::BIT_W);
      end else begin
        rd_addr = bba_pkg::waddr_t'(in_idx_ext >> bba_pkg::BIT_W);
      end
    end else begin
      rd_addr = scan_w_r + bba_pkg::waddr_t'(1);
    end
  end

  // Write-back of the modified word
  always_comb begin
    wr_en   = 1'b0;
    wr_word = cur_word;
    if (state_r == S_EVAL) begin
      case (mode_r)
        bba_pkg::MODE_ALLOC: begin
          wr_en   = hit;
          wr_word = cur_word | (bba_pkg::word_t'(1) << hit_pos);
        end
        bba_pkg::MODE_RESERVE: begin
          wr_en   = 1'b1;
          wr_word = cur_word | op_mask;
        end
        bba_pkg::MODE_FREE: begin
          wr_en   = 1'b1;
          wr_word = cur_word & ~op_mask;
        end
        default: begin
          wr_en   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[scan_w_r] <= wr_word;
    end
    rd_word_r <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[scan_w_r] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      total_r <= bba_pkg::TOTAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bba_pkg::CFG_FIRST_DATA: first_r <= cfg_wdata[bba_pkg::FIRST_W-1:0];
        bba_pkg::CFG_TOTAL:      total_r <= cfg_wdata[bba_pkg::TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_if.mode == bba_pkg::MODE_ALLOC) begin
            state_nxt = (first_ext >= search_end) ? S_RESP : S_EVAL;
          end else begin
            state_nxt = (in_idx_ext >= limit) ? S_RESP : S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (mode_r != bba_pkg::MODE_ALLOC || hit || last_word) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request context and pending result
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_xfer) begin
      mode_r       <= in_if.mode;
      idx_r        <= in_if.block_index;
      scan_w_r     <= rd_addr;
      res_ofs_en_r <= 1'b0;
      res_bit_r    <= 1'b0;
      if (in_if.mode == bba_pkg::MODE_ALLOC) begin
        res_status_r <= bba_pkg::ST_FULL;
        res_blk_r    <= '0;
      end else begin
        res_status_r <= bba_pkg::ST_RANGE;
        res_blk_r    <= in_idx_ext;
      end
    end else if (state_r == S_EVAL) begin
      if (mode_r == bba_pkg::MODE_ALLOC) begin
        if (hit) begin
          res_status_r <= bba_pkg::ST_OK;
          res_blk_r    <= base | bba_pkg::cnt_t'(hit_pos);
          res_ofs_en_r <= 1'b1;
        end else if (!last_word) begin
          // advance to the word being read
          scan_w_r <= rd_addr;
        end
      end else begin
        res_status_r <= bba_pkg::ST_OK;
        res_bit_r    <= (mode_r == bba_pkg::MODE_TEST) && ((cur_word & op_mask) != '0);
      end
    end
  end

  assign prod = bba_pkg::mul_t'(res_blk_r) * bba_pkg::mul_t'(bba_pkg::BLOCK_BYTES);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RESP && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESP && out_free) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_blk_r[bba_pkg::IDX_W-1:0];
      out_ofs_r    <= res_ofs_en_r ? prod[bba_pkg::OFS_W-1:0] : '0;
      out_bit_r    <= res_bit_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.found_index = out_found_r;
  assign out_if.byte_offset = out_ofs_r;
  assign out_if.bit_value   = out_bit_r;

endmodule

/* design/bba_checker.sv */
module bba_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [bba_pkg::STATUS_W-1:0]      out_status,
  input  logic [bba_pkg::IDX_W-1:0]         out_found_index,
  input  logic [bba_pkg::OFS_W-1:0]         out_byte_offset,
  input  logic                              out_bit_value
);

  // Held result must not change until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_found_index) && $stable(out_byte_offset) && $stable(out_bit_value))
    else $error("stalled result changed");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented straight after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == bba_pkg::ST_OK || out_status == bba_pkg::ST_FULL
      || out_status == bba_pkg::ST_RANGE)
    else $error("undefined status code");

  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bba_pkg::ST_OK |-> out_byte_offset == '0 && !out_bit_value)
    else $error("failed request carries offset or bit");

  a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bba_pkg::ST_FULL |-> out_found_index == '0)
    else $error("full status with non-zero index");

endmodule

bind block_bitmap_allocator_unit bba_checker u_bba_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_status      (out_if.status),
  .out_found_index (out_if.found_index),
  .out_byte_offset (out_if.byte_offset),
  .out_bit_value   (out_if.bit_value)
);

/* sim/block_bitmap_allocator_unit_tb.sv */
module block_bitmap_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int DIR_ROWS    = 26;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 88;

  typedef struct packed {
    bba_pkg::status_t              status;
    logic [bba_pkg::IDX_W-1:0]     found;
    logic [bba_pkg::OFS_W-1:0]     ofs;
    logic                          bitv;
  } alloc_reply_t;

  typedef struct packed {
    logic                          cfg;
    logic [bba_pkg::FIRST_W-1:0]   first;
    logic [bba_pkg::TOTAL_W-1:0]   total;
    bba_pkg::mode_t                op;
    logic [bba_pkg::IDX_W-1:0]     blk;
    logic                          typed;
    alloc_reply_t                  want;
  } dir_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we;
  bba_pkg::cfg_idx_t              cfg_index;
  logic [bba_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bba_req_if req_if ();
  bba_rsp_if rsp_if ();

  block_bitmap_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (req_if),
    .out_if    (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Mirror of the usage map and geometry registers
  bit           block_used [bba_pkg::NUM_BLOCKS];
  int           geo_first = 0;
  int           geo_total = int'(bba_pkg::TOTAL_RESET);

  alloc_reply_t pending_replies [$];
  logic         typed_on = 1'b0;
  alloc_reply_t typed_want = '0;
  int           fail_count = 0;
  int           idle_cycles = 0;
  int           snd_idle_pct = 0;
  int           rcv_stall_pct = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_TEST, 12'd0, 1'b1,
      '{bba_pkg::ST_OK, 12'd0, 24'd0, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_ALLOC, 12'd0, 1'b1,
      '{bba_pkg::ST_OK, 12'd0, 24'd0, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_ALLOC, 12'd0, 1'b1,
      '{bba_pkg::ST_OK, 12'd1, 24'd4096, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_RESERVE, 12'd2, 1'b1,
      '{bba_pkg::ST_OK, 12'd2, 24'd0, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_ALLOC, 12'd0, 1'b1,
      '{bba_pkg::ST_OK, 12'd3, 24'd12288, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_FREE, 12'd1, 1'b1,
      '{bba_pkg::ST_OK, 12'd1, 24'd0, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_FREE, 12'd1, 1'b1,
      '{bba_pkg::ST_OK, 12'd1, 24'd0, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_ALLOC, 12'd4095, 1'b1,
      '{bba_pkg::ST_OK, 12'd1, 24'd4096, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_RESERVE, 12'd4095, 1'b1,
      '{bba_pkg::ST_OK, 12'd4095, 24'd0, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_TEST, 12'd4095, 1'b1,
      '{bba_pkg::ST_OK, 12'd4095, 24'd0, 1'b1}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_FREE, 12'd4095, 1'b1,
      '{bba_pkg::ST_OK, 12'd4095, 24'd0, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_TEST, 12'd4095, 1'b1,
      '{bba_pkg::ST_OK, 12'd4095, 24'd0, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_RESERVE, 12'd2, 1'b1,
      '{bba_pkg::ST_OK, 12'd2, 24'd0, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_TEST, 12'd2, 1'b1,
      '{bba_pkg::ST_OK, 12'd2, 24'd0, 1'b1}},
    '{1'b1, 12'd4095, 13'd4096, bba_pkg::MODE_ALLOC, 12'd0, 1'b1,
      '{bba_pkg::ST_FULL, 12'd0, 24'd0, 1'b0}},
    '{1'b1, 12'd0, 13'd0, bba_pkg::MODE_ALLOC, 12'd0, 1'b1,
      '{bba_pkg::ST_FULL, 12'd0, 24'd0, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_TEST, 12'd0, 1'b1,
      '{bba_pkg::ST_RANGE, 12'd0, 24'd0, 1'b0}},
    '{1'b1, 12'd0, 13'd1, bba_pkg::MODE_ALLOC, 12'd0, 1'b1,
      '{bba_pkg::ST_FULL, 12'd0, 24'd0, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_TEST, 12'd0, 1'b1,
      '{bba_pkg::ST_OK, 12'd0, 24'd0, 1'b1}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_RESERVE, 12'd1, 1'b1,
      '{bba_pkg::ST_RANGE, 12'd1, 24'd0, 1'b0}},
    '{1'b1, 12'd0, 13'd5, bba_pkg::MODE_ALLOC, 12'd0, 1'b1,
      '{bba_pkg::ST_FULL, 12'd0, 24'd0, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_FREE, 12'd4095, 1'b1,
      '{bba_pkg::ST_RANGE, 12'd4095, 24'd0, 1'b0}},
    '{1'b1, 12'd4, 13'd6, bba_pkg::MODE_ALLOC, 12'd0, 1'b1,
      '{bba_pkg::ST_OK, 12'd4, 24'd16384, 1'b0}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_ALLOC, 12'd0, 1'b1,
      '{bba_pkg::ST_FULL, 12'd0, 24'd0, 1'b0}},
    '{1'b1, 12'd0, 13'd4096, bba_pkg::MODE_TEST, 12'd4, 1'b1,
      '{bba_pkg::ST_OK, 12'd4, 24'd0, 1'b1}},
    '{1'b0, 12'd0, 13'd0, bba_pkg::MODE_ALLOC, 12'd0, 1'b0,
      '{bba_pkg::ST_OK, 12'd0, 24'd0, 1'b0}}
  };

  // First-fit allocation and bit operations on the mirrored map
  function automatic alloc_reply_t predict_reply(bba_pkg::mode_t op,
                                                 logic [bba_pkg::IDX_W-1:0] blk);
    alloc_reply_t r;
    int           lim;
    int           stop;
    bit           hit;
    longint       ofs_full;
    r = '0;
    hit = 1'b0;
    lim = (geo_total < bba_pkg::NUM_BLOCKS) ? geo_total : bba_pkg::NUM_BLOCKS;
    if (op == bba_pkg::MODE_ALLOC) begin
      stop = (geo_total > 0) ? geo_total - 1 : 0;
      if (stop > lim) stop = lim;
      for (int b = geo_first; b < stop && !hit; b++) begin
        if (!block_used[b]) begin
          block_used[b] = 1'b1;
          hit = 1'b1;
          ofs_full = longint'(b) * bba_pkg::BLOCK_BYTES;
          r.found = b[bba_pkg::IDX_W-1:0];
          r.ofs = ofs_full[bba_pkg::OFS_W-1:0];
        end
      end
      r.status = hit ? bba_pkg::ST_OK : bba_pkg::ST_FULL;
    end else begin
      r.found = blk;
      if (int'(blk) >= lim) begin
        r.status = bba_pkg::ST_RANGE;
      end else begin
        case (op)
          bba_pkg::MODE_RESERVE: block_used[blk] = 1'b1;
          bba_pkg::MODE_FREE:    block_used[blk] = 1'b0;
          default:               r.bitv = block_used[blk];
        endcase
      end
    end
    return r;
  endfunction

  task automatic post_request(bba_pkg::mode_t op, logic [bba_pkg::IDX_W-1:0] blk);
    @(negedge clk);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < snd_idle_pct) @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= op;
    req_if.block_index <= blk;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
  endtask

  // Hold the request channel low until every reply is back
  task automatic drain_requests();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic program_geometry(int first, int total);
    drain_requests();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= bba_pkg::CFG_FIRST_DATA;
    cfg_wdata <= first[bba_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= bba_pkg::CFG_TOTAL;
    cfg_wdata <= total[bba_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    alloc_reply_t want;
    alloc_reply_t got;
    bit           moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          bba_pkg::CFG_FIRST_DATA: geo_first = int'(cfg_wdata[bba_pkg::FIRST_W-1:0]);
          bba_pkg::CFG_TOTAL:      geo_total = int'(cfg_wdata);
          default: ;
        endcase
      end
      if ((rsp_if.valid & rsp_if.ready) === 1'b1) begin
        moved = 1'b1;
        got = '{rsp_if.status, rsp_if.found_index, rsp_if.byte_offset, rsp_if.bit_value};
        if (pending_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] reply with none outstanding: status %0d index %0d",
                     $time, got.status, got.found);
        end else begin
          want = pending_replies.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.ofs !== want.ofs || got.bitv !== want.bitv) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] reply mismatch (exp/got): status %0d/%0d index %0d/%0d %s",
                       $time, want.status, got.status, want.found, got.found,
                       $sformatf("offset %0d/%0d bit %0d/%0d",
                                 want.ofs, got.ofs, want.bitv, got.bitv));
          end
        end
      end
      if ((req_if.valid & req_if.ready) === 1'b1) begin
        moved = 1'b1;
        want = predict_reply(req_if.mode, req_if.block_index);
        if (typed_on) want = typed_want;
        pending_replies.push_back(want);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** block_bitmap_allocator_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int             first;
    int             total;
    int             hold_at;
    int             pick;
    int             v;
    bba_pkg::mode_t op;
    req_if.valid       = 1'b0;
    req_if.mode        = bba_pkg::MODE_ALLOC;
    req_if.block_index = '0;
    rsp_if.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = bba_pkg::CFG_FIRST_DATA;
    cfg_wdata          = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].cfg) program_geometry(dir_rows[i].first, dir_rows[i].total);
      // swap the typed reply only once the previous transfer has been logged
      @(negedge clk);
      typed_on   = dir_rows[i].typed;
      typed_want = dir_rows[i].want;
      post_request(dir_rows[i].op, dir_rows[i].blk);
    end
    typed_on = 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1:       begin snd_idle_pct = 69; rcv_stall_pct = 0;  end
        2:       begin snd_idle_pct = 0;  rcv_stall_pct = 69; end
        default: begin snd_idle_pct = 33; rcv_stall_pct = 33; end
      endcase
      case (ph)
        0: begin first = 0;    total = 4096; end
        2: begin first = 4090; total = 4096; end
        4: begin first = $urandom_range(0, 3); total = $urandom_range(0, 3); end
        6: begin first = $urandom_range(0, 4095); total = $urandom_range(0, 4096); end
        default: begin
          total = $urandom_range(40, 300);
          first = $urandom_range(0, total / 4);
        end
      endcase
      program_geometry(first, total);
      hold_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == hold_at) drain_requests();
        pick = $urandom_range(0, 99);
        if (pick < 40)      op = bba_pkg::MODE_ALLOC;
        else if (pick < 55) op = bba_pkg::MODE_RESERVE;
        else if (pick < 80) op = bba_pkg::MODE_FREE;
        else                op = bba_pkg::MODE_TEST;
        // Aim most indices at the search window and the range boundary
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          v = first + $urandom_range(0, 40);
          if (v > 4095) v = 4095;
        end else if (pick < 75) begin
          v = $urandom_range(0, (total + 1 > 4095) ? 4095 : total + 1);
        end else begin
          v = $urandom_range(0, 4095);
        end
        post_request(op, v[bba_pkg::IDX_W-1:0]);
      end
    end

    drain_requests();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending_replies.size() == 0)
      $display("** block_bitmap_allocator_unit: PASSED **");
    else
      $display("** block_bitmap_allocator_unit: FAILED **");
    $finish;
  end

endmodule
